### sv/hsv2rgb_pkg.sv
// shared types, sector codes and byte expansion functions for the hsv to rgb565 converter
`timescale 1ns / 1ps
`default_nettype none
package hsv2rgb_pkg;

	// full-scale byte and its square
	localparam logic [7:0]  FULL8    = 8'd255;
	localparam logic [15:0] FULL8_SQ = 16'd65025;

	// hue sector codes, named by the primary and secondary hues they run between
	typedef enum logic [2:0] {
		SEC_RY = 3'd0,
		SEC_YG = 3'd1,
		SEC_GC = 3'd2,
		SEC_CB = 3'd3,
		SEC_BM = 3'd4,
		SEC_MR = 3'd5
	} sector_t;

	// per-stage load enables for the level datapath
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	// floor(q*255/31) = 8q + floor(7q/31)
	function automatic logic [7:0] expand5(input logic [4:0] q);
		logic [7:0] q7;
		logic [7:0] frac;
		q7 = 8'(q) * 8'd7;
		frac = '0;
		for (int k = 1; k <= 7; k++) begin
			if (q7 >= 8'(31 * k))
				frac = frac + 8'd1;
		end
		return {q, 3'b000} + frac;
	endfunction

	// floor(q*255/63) = 4q + floor(q/21)
	function automatic logic [7:0] expand6(input logic [5:0] q);
		logic [7:0] frac;
		if (q >= 6'd63)
			frac = 8'd3;
		else if (q >= 6'd42)
			frac = 8'd2;
		else if (q >= 6'd21)
			frac = 8'd1;
		else
			frac = 8'd0;
		return {q, 2'b00} + frac;
	endfunction

endpackage
`default_nettype wire

### sv/hsv2rgb_if.sv
// valid/ready channel interfaces for hsv pixel words and rgb pixel words
`timescale 1ns / 1ps
`default_nettype none
interface hsv2rgb_hsv_if;
	logic       valid;
	logic       ready;
	logic [7:0] hue;
	logic [7:0] saturation;
	logic [7:0] brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

interface hsv2rgb_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

### sv/hsv2rgb_hue.sv
// hue decode: sector number and distance of the hue from the midpoint of its sector pair
`timescale 1ns / 1ps
`default_nettype none
module hsv2rgb_hue
	import hsv2rgb_pkg::*;
(
	input  wire logic [7:0] hue,
	output sector_t         sector,
	output logic [7:0]      hue_dist
);

	logic [10:0] pos;
	logic [8:0]  rem;

	// sector position 6*hue, in units of 1/255 sector
	assign pos = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

	// sector from threshold compares, top hue wraps to sector zero
	always_comb begin
		if (pos >= 11'd1530)
			sector = SEC_RY;
		else if (pos >= 11'd1275)
			sector = SEC_MR;
		else if (pos >= 11'd1020)
			sector = SEC_BM;
		else if (pos >= 11'd765)
			sector = SEC_CB;
		else if (pos >= 11'd510)
			sector = SEC_GC;
		else if (pos >= 11'd255)
			sector = SEC_YG;
		else
			sector = SEC_RY;
	end

	// position within a sector pair
	always_comb begin
		if (pos >= 11'd1530)
			rem = 9'(pos - 11'd1530);
		else if (pos >= 11'd1020)
			rem = 9'(pos - 11'd1020);
		else if (pos >= 11'd510)
			rem = 9'(pos - 11'd510);
		else
			rem = 9'(pos);
	end

	// |rem - 255|
	assign hue_dist = (rem >= 9'd255) ? 8'(rem - 9'd255) : 8'(9'd255 - rem);

endmodule
`default_nettype wire

### sv/hsv2rgb_levels.sv
// level datapath: products and rounded divisions by 255 and 65025, four register stages
`timescale 1ns / 1ps
`default_nettype none
module hsv2rgb_levels
	import hsv2rgb_pkg::*;
(
	input  wire logic       clk,
	input  wire pipe_en_t   en,
	input  wire sector_t    sec_s1,
	input  wire logic [7:0] sat_s1,
	input  wire logic [7:0] bri_s1,
	input  wire logic [7:0] dist_s1,
	output sector_t         sec_s5,
	output logic [7:0]      bri_s5,
	output logic [7:0]      bz_s5,
	output logic [7:0]      bx_s5
);

	sector_t     sec_s2, sec_s3, sec_s4;
	logic [7:0]  bri_s2, bri_s3, bri_s4;
	logic [15:0] nz_s2;
	logic [15:0] t_s2;
	logic [23:0] yx_s3, yx_s4;
	logic [15:0] yz_s3;
	logic [7:0]  qz0_s3;
	logic [7:0]  qx0_s4;
	logic [7:0]  bz_s4;

	logic [15:0] yz;
	logic [24:0] yz_prod;
	logic [40:0] yx_prod;
	logic [15:0] rz;
	logic [23:0] rx;

	// stage 2: zero-channel numerator and x-channel weight 65025 - s*dist
	always_ff @(posedge clk) begin
		if (en.s2) begin
			nz_s2  <= 16'(bri_s1) * 16'(FULL8 - sat_s1);
			t_s2   <= FULL8_SQ - 16'(sat_s1) * 16'(dist_s1);
			bri_s2 <= bri_s1;
			sec_s2 <= sec_s1;
		end
	end

	// stage 3: rounding bias, first estimate of the zero-channel quotient
	assign yz      = nz_s2 + 16'd127;
	assign yz_prod = 25'(yz) * 25'd257;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			yx_s3  <= 24'(bri_s2) * 24'(t_s2) + 24'd32512;
			yz_s3  <= yz;
			qz0_s3 <= yz_prod[23:16];
			bri_s3 <= bri_s2;
			sec_s3 <= sec_s2;
		end
	end

	// stage 4: zero-channel correction, x-channel reciprocal estimate
	assign rz      = yz_s3 - 16'(qz0_s3) * 16'(FULL8);
	assign yx_prod = 41'(yx_s3) * 41'd66049;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			bz_s4  <= qz0_s3 + 8'(rz >= 16'(FULL8));
			qx0_s4 <= yx_prod[39:32];
			yx_s4  <= yx_s3;
			bri_s4 <= bri_s3;
			sec_s4 <= sec_s3;
		end
	end

	// stage 5: x-channel correction
	assign rx = yx_s4 - 24'(qx0_s4) * 24'(FULL8_SQ);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			bx_s5  <= qx0_s4 + 8'(rx >= 24'(FULL8_SQ));
			bz_s5  <= bz_s4;
			bri_s5 <= bri_s4;
			sec_s5 <= sec_s4;
		end
	end

endmodule
`default_nettype wire

### sv/hsv2rgb_pack.sv
// channel steering by sector and rgb565 quantize and expand
`timescale 1ns / 1ps
`default_nettype none
module hsv2rgb_pack
	import hsv2rgb_pkg::*;
(
	input  wire sector_t    sector,
	input  wire logic [7:0] bc,
	input  wire logic [7:0] bz,
	input  wire logic [7:0] bx,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue
);

	logic [7:0] r, g, b;

	// route chroma, secondary and floor levels to channels
	always_comb begin
		case (sector)
			SEC_RY: begin r = bc; g = bx; b = bz; end
			SEC_YG: begin r = bx; g = bc; b = bz; end
			SEC_GC: begin r = bz; g = bc; b = bx; end
			SEC_CB: begin r = bz; g = bx; b = bc; end
			SEC_BM: begin r = bx; g = bz; b = bc; end
			default: begin r = bc; g = bz; b = bx; end
		endcase
	end

	// truncate to 5/6/5 and expand back to a byte
	assign red   = expand5(r[7:3]);
	assign green = expand6(g[7:2]);
	assign blue  = expand5(b[7:3]);

endmodule
`default_nettype wire

### sv/hsv_to_rgb565_color.sv
// top level of the hsv to rgb565-quantized rgb converter
// Converts one 8-bit HSV pixel per clock, while the output side is ready, into
// RGB bytes that have been cut to 5/6/5 bits and expanded back to 0..255. The
// block takes a new word every cycle while the output side is ready; six
// register stages sit between the ports, the longest of which holds the 24x17
// reciprocal multiply that divides by 65025. A stall on the output freezes the
// whole pipeline, but empty stages keep filling, so input ready stays high
// until every stage holds a word.
`timescale 1ns / 1ps
`default_nettype none
module hsv_to_rgb565_color
	import hsv2rgb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	hsv2rgb_hsv_if.sink    pix_in,
	hsv2rgb_rgb_if.source  pix_out
);

	logic en1, en2, en3, en4, en5, en6;
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6;
	pipe_en_t en;

	sector_t    sec_hue;
	logic [7:0] dist_hue;

	sector_t    sec_s1;
	logic [7:0] sat_s1, bri_s1, dist_s1;

	sector_t    sec_s5;
	logic [7:0] bri_s5, bz_s5, bx_s5;

	logic [7:0] red_c, green_c, blue_c;
	logic [7:0] red_s6, green_s6, blue_s6;

	// stage enables: a stage loads when it is empty or the next one moves
	assign en6 = !v6_s6 || pix_out.ready;
	assign en5 = !v5_s5 || en6;
	assign en4 = !v4_s4 || en5;
	assign en3 = !v3_s3 || en4;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;

	assign en = '{s2: en2, s3: en3, s4: en4, s5: en5};

	assign pix_in.ready = en1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
			v6_s6 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= pix_in.valid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
			if (en5) v5_s5 <= v4_s4;
			if (en6) v6_s6 <= v5_s5;
		end
	end

	// stage 1: hue decode
	hsv2rgb_hue u_hue (
		.hue      (pix_in.hue),
		.sector   (sec_hue),
		.hue_dist (dist_hue)
	);

	always_ff @(posedge clk) begin
		if (en1) begin
			sec_s1  <= sec_hue;
			dist_s1 <= dist_hue;
			sat_s1  <= pix_in.saturation;
			bri_s1  <= pix_in.brightness;
		end
	end

	// stages 2 to 5: channel levels
	hsv2rgb_levels u_levels (
		.clk     (clk),
		.en      (en),
		.sec_s1  (sec_s1),
		.sat_s1  (sat_s1),
		.bri_s1  (bri_s1),
		.dist_s1 (dist_s1),
		.sec_s5  (sec_s5),
		.bri_s5  (bri_s5),
		.bz_s5   (bz_s5),
		.bx_s5   (bx_s5)
	);

	// stage 6: steering, quantize and output register
	hsv2rgb_pack u_pack (
		.sector (sec_s5),
		.bc     (bri_s5),
		.bz     (bz_s5),
		.bx     (bx_s5),
		.red    (red_c),
		.green  (green_c),
		.blue   (blue_c)
	);

	always_ff @(posedge clk) begin
		if (en6) begin
			red_s6   <= red_c;
			green_s6 <= green_c;
			blue_s6  <= blue_c;
		end
	end

	assign pix_out.valid = v6_s6;
	assign pix_out.red   = red_s6;
	assign pix_out.green = green_s6;
	assign pix_out.blue  = blue_s6;

endmodule
`default_nettype wire

### sv/hsv2rgb_chk.sv
// port-level checker for the hsv to rgb565 converter and its bind
`timescale 1ns / 1ps
`default_nettype none
module hsv2rgb_chk
	import hsv2rgb_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] red,
	input wire logic [7:0] green,
	input wire logic [7:0] blue
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue))
		else $error("output word changed while stalled");

	// pipeline takes input whenever its last stage can move
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input not ready while output side can drain");

	// red and blue are 5-bit levels expanded to a byte
	a_rb_565: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (red == expand5(red[7:3])) && (blue == expand5(blue[7:3])))
		else $error("red or blue byte is not an expanded 5-bit level");

	// green is a 6-bit level expanded to a byte
	a_g_565: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> green == expand6(green[7:2]))
		else $error("green byte is not an expanded 6-bit level");

	// output valid is known after every accepted input word
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$isunknown(out_valid))
		else $error("output valid unknown after accept");

endmodule

bind hsv_to_rgb565_color hsv2rgb_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.red       (pix_out.red),
	.green     (pix_out.green),
	.blue      (pix_out.blue)
);
`default_nettype wire

### sim/hsv_to_rgb565_color_tb.sv
// self-checking testbench for the hsv to rgb565-quantized rgb converter
`timescale 1ns / 1ps
module hsv_to_rgb565_color_tb;
	import hsv2rgb_pkg::*;

	localparam int unsigned BYTE_MAX  = 255;
	localparam int unsigned BYTE_SQ   = 65025;
	localparam int          IDLE_PCT  = 18;
	localparam int          PIPE_LAT  = 6;
	localparam int          MAX_SHOWN = 10;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_word_t;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
		rgb_word_t  rgb;
	} pending_pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hsv2rgb_hsv_if hsv_ch ();
	hsv2rgb_rgb_if rgb_ch ();

	hsv_to_rgb565_color dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (hsv_ch),
		.pix_out (rgb_ch)
	);

	pending_pixel_t rgb_pending[$];
	int             mismatch_count = 0;
	int             stall_cycles = 0;
	bit             steady_in = 1'b0;
	bit             steady_out = 1'b0;

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// division rounded half away from zero
	function automatic int unsigned round_div(input int unsigned num, input int unsigned den);
		return (2 * num + den) / (2 * den);
	endfunction

	function automatic int unsigned clamp_level(input int unsigned lvl);
		return (lvl > BYTE_MAX) ? BYTE_MAX : lvl;
	endfunction

	// cut a byte to n bits and stretch the level back to 0..255
	function automatic logic [7:0] requantize(input int unsigned lvl, input int unsigned bits);
		int unsigned q;
		int unsigned top;
		q = lvl >> (8 - bits);
		top = (1 << bits) - 1;
		return 8'((q * BYTE_MAX) / top);
	endfunction

	// six-sector hsv to rgb rule followed by 5/6/5 quantization
	function automatic rgb_word_t predict_rgb565(input logic [7:0] h, input logic [7:0] s,
		input logic [7:0] v);
		int unsigned hv, sv, vv;
		int unsigned pos, rem2, offs, frac;
		int unsigned lvl_c, lvl_z, lvl_x;
		int unsigned r, g, b;
		sector_t     sec;
		rgb_word_t   w;
		hv = h;
		sv = s;
		vv = v;
		pos = 6 * hv;
		rem2 = pos % (2 * BYTE_MAX);
		offs = (rem2 >= BYTE_MAX) ? rem2 - BYTE_MAX : BYTE_MAX - rem2;
		frac = BYTE_MAX - offs;
		lvl_c = clamp_level(vv);
		lvl_z = clamp_level(round_div(vv * (BYTE_MAX - sv), BYTE_MAX));
		lvl_x = clamp_level(round_div(vv * (sv * frac + BYTE_SQ - BYTE_MAX * sv), BYTE_SQ));
		// the top hue lands on the full circle and wraps to red
		if (pos / BYTE_MAX >= 6)
			sec = SEC_RY;
		else
			sec = sector_t'(pos / BYTE_MAX);
		case (sec)
			SEC_RY: begin r = lvl_c; g = lvl_x; b = lvl_z; end
			SEC_YG: begin r = lvl_x; g = lvl_c; b = lvl_z; end
			SEC_GC: begin r = lvl_z; g = lvl_c; b = lvl_x; end
			SEC_CB: begin r = lvl_z; g = lvl_x; b = lvl_c; end
			SEC_BM: begin r = lvl_x; g = lvl_z; b = lvl_c; end
			default: begin r = lvl_c; g = lvl_z; b = lvl_x; end
		endcase
		w.red = requantize(r, 5);
		w.green = requantize(g, 6);
		w.blue = requantize(b, 5);
		return w;
	endfunction

	// mostly uniform bytes, with a share of range edges and midpoints
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(1) ? 127 : 128);
			3: return 8'($urandom_range(1) ? 1 : 254);
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// offer one hsv word and record its expected rgb word once accepted
	task automatic send_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v);
		pending_pixel_t p;
		if (!steady_in) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				hsv_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		hsv_ch.valid <= 1'b1;
		hsv_ch.hue <= h;
		hsv_ch.saturation <= s;
		hsv_ch.brightness <= v;
		@(posedge clk);
		while (!hsv_ch.ready)
			@(posedge clk);
		p.hue = h;
		p.saturation = s;
		p.brightness = v;
		p.rgb = predict_rgb565(h, s, v);
		rgb_pending = {rgb_pending, p};
	endtask

	// stop offering and wait until every expected word has come back
	task automatic wait_all_results();
		hsv_ch.valid <= 1'b0;
		@(posedge clk);
		while (rgb_pending.size() != 0)
			@(posedge clk);
	endtask

	// range extremes, every sector edge, the wrapping top hue, gray and black
	task automatic test_directed();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd42, 8'd255, 8'd255);
		send_pixel(8'd43, 8'd255, 8'd255);
		send_pixel(8'd85, 8'd255, 8'd255);
		send_pixel(8'd127, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd255, 8'd255);
		send_pixel(8'd170, 8'd255, 8'd255);
		send_pixel(8'd212, 8'd255, 8'd255);
		send_pixel(8'd213, 8'd255, 8'd255);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd128, 8'd200);
		send_pixel(8'd100, 8'd0, 8'd255);
		send_pixel(8'd100, 8'd0, 8'd7);
		send_pixel(8'd200, 8'd255, 8'd0);
		send_pixel(8'd170, 8'd1, 8'd1);
		send_pixel(8'd85, 8'd254, 8'd254);
		send_pixel(8'haa, 8'h55, 8'haa);
		send_pixel(8'h55, 8'haa, 8'h55);
		send_pixel(8'd21, 8'd128, 8'd255);
		send_pixel(8'd64, 8'd127, 8'd129);
		wait_all_results();
	endtask

	// random pixels with idling on both sides
	task automatic test_random_stream(input int count);
		for (int i = 0; i < count; i++)
			send_pixel(pick_byte(), pick_byte(), pick_byte());
		wait_all_results();
	endtask

	// full-rate stretch, no idle cycles on either side
	task automatic test_back_to_back(input int count);
		steady_in = 1'b1;
		steady_out = 1'b1;
		for (int i = 0; i < count; i++)
			send_pixel(pick_byte(), pick_byte(), pick_byte());
		steady_in = 1'b0;
		steady_out = 1'b0;
		wait_all_results();
	endtask

	// long output stall while the input keeps offering, so the pipeline fills
	task automatic test_output_stall(input int count);
		steady_in = 1'b1;
		stall_cycles = 60;
		for (int i = 0; i < count; i++)
			send_pixel(pick_byte(), pick_byte(), pick_byte());
		steady_in = 1'b0;
		wait_all_results();
	endtask

	// output ready: random back-pressure, steady stretches and long stalls
	initial begin
		rgb_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_cycles > 0) begin
				rgb_ch.ready <= 1'b0;
				stall_cycles--;
			end else if (steady_out) begin
				rgb_ch.ready <= 1'b1;
			end else begin
				rgb_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// compare each returned word with the oldest expectation
	always @(posedge clk) begin
		pending_pixel_t p;
		if (arst_n && rgb_ch.valid && rgb_ch.ready) begin
			if (rgb_pending.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_SHOWN)
					$display("%0t: unexpected rgb word r=%0d g=%0d b=%0d", $realtime,
						rgb_ch.red, rgb_ch.green, rgb_ch.blue);
			end else begin
				p = rgb_pending.pop_front();
				if (rgb_ch.red !== p.rgb.red || rgb_ch.green !== p.rgb.green ||
					rgb_ch.blue !== p.rgb.blue) begin
					mismatch_count++;
					if (mismatch_count <= MAX_SHOWN)
						$display("%0t: h=%0d s=%0d v=%0d expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
							$realtime, p.hue, p.saturation, p.brightness,
							p.rgb.red, p.rgb.green, p.rgb.blue,
							rgb_ch.red, rgb_ch.green, rgb_ch.blue);
				end
			end
		end
	end

	// watchdog
	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

	// test sequence
	initial begin
		int waited;
		hsv_ch.valid <= 1'b0;
		hsv_ch.hue <= 8'd0;
		hsv_ch.saturation <= 8'd0;
		hsv_ch.brightness <= 8'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_stream(1500);
		test_output_stall(80);
		test_back_to_back(200);

		// let the pipeline settle after the last word
		waited = 0;
		while (rgb_pending.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (PIPE_LAT * 4) @(posedge clk);
		if (mismatch_count == 0 && rgb_pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### filelist.f
sv/hsv2rgb_pkg.sv
sv/hsv2rgb_if.sv
sv/hsv2rgb_hue.sv
sv/hsv2rgb_levels.sv
sv/hsv2rgb_pack.sv
sv/hsv_to_rgb565_color.sv
sv/hsv2rgb_chk.sv
sim/hsv_to_rgb565_color_tb.sv
